// ===== rtl/core/crcbc_pkg.sv =====
// Shared types, constants and helper functions for the configurable CRC block.
`default_nettype none

package crcbc_pkg;

  localparam int unsigned CRC_W      = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    WSEL_8  = 2'd0,
    WSEL_16 = 2'd1,
    WSEL_32 = 2'd2,
    WSEL_RSV = 2'd3
  } wsel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_SELECT  = 3'd0,
    REG_POLYNOMIAL    = 3'd1,
    REG_INITIAL_VALUE = 3'd2,
    REG_FINAL_XOR     = 3'd3,
    REG_REFLECTED     = 3'd4
  } cfg_reg_t;

  localparam logic [1:0]       RST_WIDTH_SELECT  = 2'd2;
  localparam logic [CRC_W-1:0] RST_POLYNOMIAL    = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] RST_INITIAL_VALUE = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] RST_FINAL_XOR     = 32'hFFFF_FFFF;
  localparam logic             RST_REFLECTED     = 1'b1;

  typedef struct packed {
    logic [1:0]       width_select;
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] initial_value;
    logic [CRC_W-1:0] final_xor;
    logic             reflected;
  } crc_cfg_t;

  function automatic logic [CRC_W-1:0] width_mask(input logic [1:0] wsel);
    logic [CRC_W-1:0] m;
    case (wsel)
      WSEL_8:  m = 32'h0000_00FF;
      WSEL_16: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [CRC_W-1:0] bit_rev(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int k = 0; k < CRC_W; k++) begin
      r[k] = v[CRC_W-1-k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crcbc_cfg_regs.sv =====
// Configuration register file of the configurable CRC block.
`default_nettype none

module crcbc_cfg_regs
  import crcbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CRC_W-1:0]     cfg_data,
  output crc_cfg_t                  cfg
);

  crc_cfg_t cfg_r;
  crc_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH_SELECT:  cfg_nxt.width_select  = cfg_data[1:0];
        REG_POLYNOMIAL:    cfg_nxt.polynomial    = cfg_data;
        REG_INITIAL_VALUE: cfg_nxt.initial_value = cfg_data;
        REG_FINAL_XOR:     cfg_nxt.final_xor     = cfg_data;
        REG_REFLECTED:     cfg_nxt.reflected     = cfg_data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_select  <= RST_WIDTH_SELECT;
      cfg_r.polynomial    <= RST_POLYNOMIAL;
      cfg_r.initial_value <= RST_INITIAL_VALUE;
      cfg_r.final_xor     <= RST_FINAL_XOR;
      cfg_r.reflected     <= RST_REFLECTED;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcbc_byte_update.sv =====
// Eight-step XOR-shift update of the CRC register by one message byte.
`default_nettype none

module crcbc_byte_update
  import crcbc_pkg::*;
(
  input  wire logic [CRC_W-1:0]  crc_in,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  crc_cfg_t               cfg,
  output logic [CRC_W-1:0]       crc_out
);

  logic [CRC_W-1:0] mask;
  logic [CRC_W-1:0] poly_m;
  logic [CRC_W-1:0] rpoly;
  logic [CRC_W-1:0] byte_al;
  logic [CRC_W-1:0] poly_rev;
  logic [4:0]       top_idx;

  assign mask     = width_mask(cfg.width_select);
  assign poly_m   = cfg.polynomial & mask;
  assign poly_rev = bit_rev(poly_m);

  // Reversed polynomial is right-aligned to the selected width, and in normal
  // mode the byte sits at the top of the selected width.
  always_comb begin
    case (cfg.width_select)
      WSEL_8: begin
        rpoly   = {24'd0, poly_rev[31:24]};
        byte_al = {24'd0, data_byte};
        top_idx = 5'd7;
      end
      WSEL_16: begin
        rpoly   = {16'd0, poly_rev[31:16]};
        byte_al = {16'd0, data_byte, 8'd0};
        top_idx = 5'd15;
      end
      default: begin
        rpoly   = poly_rev;
        byte_al = {data_byte, 24'd0};
        top_idx = 5'd31;
      end
    endcase
  end

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in & mask;
    if (cfg.reflected) begin
      c = c ^ {24'd0, data_byte};
      for (int k = 0; k < BYTE_W; k++) begin
        if (c[0]) c = (c >> 1) ^ rpoly;
        else      c = c >> 1;
      end
    end else begin
      c = c ^ byte_al;
      for (int k = 0; k < BYTE_W; k++) begin
        if (c[top_idx]) c = ((c << 1) ^ poly_m) & mask;
        else            c = (c << 1) & mask;
      end
    end
    crc_out = c & mask;
  end

endmodule

`default_nettype wire

// ===== rtl/core/crc_bitwise_configurable_unit.sv =====
// Top level of the configurable bitwise CRC block: input beat register, byte update, result register.
// A beat is taken into the input beat register and then updates the CRC register; a last beat
// also loads the result register that drives out_valid, and is held back while a waiting result stalls.
// Throughput: one byte per cycle while no last beat is held, set by the eight-step byte update.
// A waiting result only holds back a following last beat; other beats keep flowing.
// Reset (rst_n low, synchronous) clears the CRC register, the beat and result valids,
// and loads the default configuration (32-bit reflected, 0x04C11DB7, all-ones init and xor).
`default_nettype none

module crc_bitwise_configurable_unit
  import crcbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_data_byte,
  input  wire logic                 in_first_byte,
  input  wire logic                 in_last_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CRC_W-1:0]          out_crc_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CRC_W-1:0]     cfg_data
);

  crc_cfg_t cfg;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_data_r;
  logic              s1_first_r;
  logic              s1_last_r;
  logic [CRC_W-1:0]  crc_r;
  logic [CRC_W-1:0]  crc_nxt;
  logic [CRC_W-1:0]  crc_base;
  logic              out_valid_r;
  logic [CRC_W-1:0]  out_crc_r;
  logic              slot_free;
  logic              adv;

  crcbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign crc_base = s1_first_r ? cfg.initial_value : crc_r;

  crcbc_byte_update u_upd (
    .crc_in    (crc_base),
    .data_byte (s1_data_r),
    .cfg       (cfg),
    .crc_out   (crc_nxt)
  );

  // A beat without a result never waits for the output side.
  assign slot_free = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && (!s1_last_r || slot_free);
  assign in_stall  = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r  <= in_data_byte;
      s1_first_r <= in_first_byte;
      s1_last_r  <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else if (adv) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_crc_r <= (crc_nxt ^ cfg.final_xor) & width_mask(cfg.width_select);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with no beat held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && out_valid_r && out_stall) |-> !adv)
    else $error("last beat advanced over a waiting result");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> out_valid_r)
    else $error("last beat did not produce a result");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_crc_r)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
